### hdl/multiword_add_sub_mul_unit_core_defines.svh
// Assertion macros shared by the multiword add, subtract and multiply unit.
`ifndef MULTIWORD_ADD_SUB_MUL_UNIT_CORE_DEFINES_SVH
`define MULTIWORD_ADD_SUB_MUL_UNIT_CORE_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MWAS_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MWAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/mwas_pkg.sv
// Shared constants and types of the multiword add, subtract and multiply unit.
package mwas_pkg;

   localparam int MAX_WORDS = 4;
   localparam int WORD_W    = 32;
   localparam int OPC_W     = 2;
   localparam int RES_DEPTH = 2 * MAX_WORDS;
   localparam int CNT_W     = $clog2(MAX_WORDS + 1);
   localparam int IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int RIDX_W    = $clog2(RES_DEPTH);
   localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

   typedef enum logic [OPC_W-1:0] {
      OPC_ADD  = 2'd0,
      OPC_SUB  = 2'd1,
      OPC_MUL  = 2'd2,
      OPC_NONE = 2'd3
   } opcode_type;

endpackage

### hdl/mwas_req_if.sv
// Request channel: one word of each operand with opcode and end marker.
interface mwas_req_if import mwas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OPC_W-1:0]  opcode;
   logic [WORD_W-1:0] a_word;
   logic [WORD_W-1:0] b_word;
   logic              last_word;

   modport source (output valid, output opcode, output a_word, output b_word,
                   output last_word, input ready);
   modport sink   (input valid, input opcode, input a_word, input b_word,
                   input last_word, output ready);
endinterface

### hdl/mwas_rsp_if.sv
// Response channel: one result word with its status bits.
interface mwas_rsp_if import mwas_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_word;
   logic              flag;
   logic              length_error;
   logic              last_result;

   modport source (output valid, output result_word, output flag,
                   output length_error, output last_result, input ready);
   modport sink   (input valid, input result_word, input flag,
                   input length_error, input last_result, output ready);
endinterface

### hdl/mwas_ram.sv
// Generic single write port, single read port RAM with registered read data.
module mwas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/multiword_add_sub_mul_unit_core.sv
// Channel   Dir  Handshake      Payload
// req_ch    in   valid/ready    opcode, a_word, b_word, last_word
// rsp_ch    out  valid/ready    result_word, flag, length_error, last_result
//
// Operand words are taken one per cycle into two operand RAMs until last_word.
// The result RAM is then cleared. Add and subtract pass S_ARITH_RD and S_ARITH_WR per
// word; a negative difference then passes S_NEG_RD and S_NEG_WR per result word. Multiply
// passes S_MUL_RD, S_MUL_PROD and S_MUL_ACC per word of a row, then S_MUL_TOP per row.
// Each result word passes S_OUT_RD and S_OUT_LD, then S_OUT_WAIT holds it until rsp_ch
// takes it; the next result word is not read before that.
// No request is taken from the last word until the final result is taken.
// Reset is synchronous and clears the control state only.
`include "multiword_add_sub_mul_unit_core_defines.svh"

module multiword_add_sub_mul_unit_core import mwas_pkg::*; (
   input logic         clock,
   input logic         reset,
   mwas_req_if.sink    req_ch,
   mwas_rsp_if.source  rsp_ch
);

   typedef enum logic [12:0] {
      S_COLLECT  = 13'b0000000000001,
      S_CLEAR    = 13'b0000000000010,
      S_ARITH_RD = 13'b0000000000100,
      S_ARITH_WR = 13'b0000000001000,
      S_NEG_RD   = 13'b0000000010000,
      S_NEG_WR   = 13'b0000000100000,
      S_MUL_RD   = 13'b0000001000000,
      S_MUL_PROD = 13'b0000010000000,
      S_MUL_ACC  = 13'b0000100000000,
      S_MUL_TOP  = 13'b0001000000000,
      S_OUT_RD   = 13'b0010000000000,
      S_OUT_LD   = 13'b0100000000000,
      S_OUT_WAIT = 13'b1000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   opcode_type          opc_ff, opc_in;
   logic                ovf_ff, ovf_in;
   logic                flag_ff, flag_in;
   logic [IDX_W-1:0]    i_ff, i_in;
   logic [IDX_W-1:0]    j_ff, j_in;
   logic [RIDX_W-1:0]   k_ff, k_in;
   logic [WORD_W-1:0]   carry_ff, carry_in;
   logic [2*WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W:0]     rc_ff, rc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   out_word_ff, out_word_in;
   logic                out_last_ff, out_last_in;

   logic                req_ready;
   logic                req_fire;
   logic                rsp_fire;

   logic                ab_we;
   logic [IDX_W-1:0]    ab_waddr;
   logic [IDX_W-1:0]    ab_raddr;
   logic [WORD_W-1:0]   a_rd, b_rd;

   logic                r_we;
   logic [RIDX_W-1:0]   r_waddr;
   logic [WORD_W-1:0]   r_wdata;
   logic [RIDX_W-1:0]   r_raddr;
   logic [WORD_W-1:0]   r_rd;

   logic [IDX_W-1:0]    n_last;
   logic [RCNT_W-1:0]   res_count;
   logic [WORD_W:0]     sum33, diff33, neg33;
   logic [2*WORD_W-1:0] acc64;

   assign req_ready = (state_ff == S_COLLECT);
   assign req_fire  = req_ch.valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ch.ready;

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_word  = out_word_ff;
   assign rsp_ch.flag         = flag_ff;
   assign rsp_ch.length_error = ovf_ff;
   assign rsp_ch.last_result  = out_last_ff;

   // Index of the last loaded word; the count is at least one while computing.
   assign n_last    = IDX_W'(cnt_ff - CNT_W'(1));
   assign res_count = (opc_ff == OPC_MUL) ? (RCNT_W'(cnt_ff) << 1) : RCNT_W'(cnt_ff);

   assign sum33  = {1'b0, a_rd} + {1'b0, b_rd} + (WORD_W+1)'(carry_ff[0]);
   assign diff33 = {1'b0, a_rd} - {1'b0, b_rd} - (WORD_W+1)'(carry_ff[0]);
   assign neg33  = {1'b0, ~r_rd} + (WORD_W+1)'(carry_ff[0]);
   assign acc64  = prod_ff + (2*WORD_W)'(rc_ff);

   assign ab_we    = req_fire && (cnt_ff < CNT_W'(MAX_WORDS));
   assign ab_waddr = cnt_ff[IDX_W-1:0];
   assign ab_raddr = (state_ff == S_MUL_RD) ? j_ff : i_ff;

   mwas_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_a_ram (
      .clock   (clock),
      .wr_en   (ab_we),
      .wr_addr (ab_waddr),
      .wr_data (req_ch.a_word),
      .rd_addr (i_ff),
      .rd_data (a_rd)
   );

   mwas_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WORDS)) u_b_ram (
      .clock   (clock),
      .wr_en   (ab_we),
      .wr_addr (ab_waddr),
      .wr_data (req_ch.b_word),
      .rd_addr (ab_raddr),
      .rd_data (b_rd)
   );

   mwas_ram #(.WIDTH(WORD_W), .DEPTH(RES_DEPTH)) u_r_ram (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      opc_in       = opc_ff;
      ovf_in       = ovf_ff;
      flag_in      = flag_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      carry_in     = carry_ff;
      prod_in      = prod_ff;
      rc_in        = rc_ff;
      rsp_valid_in = rsp_valid_ff;
      out_word_in  = out_word_ff;
      out_last_in  = out_last_ff;
      r_we         = 1'b0;
      r_waddr      = k_ff;
      r_wdata      = '0;
      r_raddr      = k_ff;

      unique case (state_ff)
         S_COLLECT: begin
            if (req_fire) begin
               if (cnt_ff == '0) begin
                  opc_in = opcode_type'(req_ch.opcode);
               end
               if (cnt_ff < CNT_W'(MAX_WORDS)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_ch.last_word) begin
                  state_in = S_CLEAR;
                  k_in     = '0;
                  i_in     = '0;
                  j_in     = '0;
                  carry_in = '0;
                  flag_in  = 1'b0;
               end
            end
         end
         S_CLEAR: begin
            r_we    = 1'b1;
            r_waddr = k_ff;
            k_in    = k_ff + RIDX_W'(1);
            if (k_ff == RIDX_W'(RES_DEPTH - 1)) begin
               k_in = '0;
               case (opc_ff) inside
                  OPC_ADD, OPC_SUB: state_in = S_ARITH_RD;
                  OPC_MUL:          state_in = S_MUL_RD;
                  default:          state_in = S_OUT_RD;
               endcase
            end
         end
         S_ARITH_RD: begin
            state_in = S_ARITH_WR;
         end
         S_ARITH_WR: begin
            r_we    = 1'b1;
            r_waddr = RIDX_W'(i_ff);
            if (opc_ff == OPC_SUB) begin
               r_wdata  = diff33[WORD_W-1:0];
               carry_in = WORD_W'(diff33[WORD_W]);
            end else begin
               r_wdata  = sum33[WORD_W-1:0];
               carry_in = WORD_W'(sum33[WORD_W]);
            end
            if (i_ff == n_last) begin
               flag_in = carry_in[0];
               k_in    = '0;
               // A negative difference is turned into its magnitude in place.
               if ((opc_ff == OPC_SUB) && carry_in[0]) begin
                  state_in = S_NEG_RD;
                  carry_in = WORD_W'(1);
               end else begin
                  state_in = S_OUT_RD;
               end
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_ARITH_RD;
            end
         end
         S_NEG_RD: begin
            r_raddr  = k_ff;
            state_in = S_NEG_WR;
         end
         S_NEG_WR: begin
            r_we     = 1'b1;
            r_waddr  = k_ff;
            r_wdata  = neg33[WORD_W-1:0];
            carry_in = WORD_W'(neg33[WORD_W]);
            if (RCNT_W'(k_ff) == res_count - RCNT_W'(1)) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               k_in     = k_ff + RIDX_W'(1);
               state_in = S_NEG_RD;
            end
         end
         S_MUL_RD: begin
            r_raddr  = RIDX_W'(i_ff) + RIDX_W'(j_ff);
            state_in = S_MUL_PROD;
         end
         S_MUL_PROD: begin
            prod_in  = a_rd * b_rd;
            rc_in    = {1'b0, r_rd} + {1'b0, carry_ff};
            state_in = S_MUL_ACC;
         end
         S_MUL_ACC: begin
            r_we     = 1'b1;
            r_waddr  = RIDX_W'(i_ff) + RIDX_W'(j_ff);
            r_wdata  = acc64[WORD_W-1:0];
            carry_in = acc64[2*WORD_W-1:WORD_W];
            if (j_ff == n_last) begin
               state_in = S_MUL_TOP;
            end else begin
               j_in     = j_ff + IDX_W'(1);
               state_in = S_MUL_RD;
            end
         end
         S_MUL_TOP: begin
            r_we     = 1'b1;
            r_waddr  = RIDX_W'(i_ff) + RIDX_W'(cnt_ff);
            r_wdata  = carry_ff;
            carry_in = '0;
            j_in     = '0;
            if (i_ff == n_last) begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_MUL_RD;
            end
         end
         S_OUT_RD: begin
            r_raddr  = k_ff;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            out_word_in  = r_rd;
            out_last_in  = (RCNT_W'(k_ff) == res_count - RCNT_W'(1));
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (out_last_ff) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = S_COLLECT;
               end else begin
                  k_in     = k_ff + RIDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         cnt_ff       <= '0;
         opc_ff       <= OPC_ADD;
         ovf_ff       <= 1'b0;
         flag_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         opc_ff       <= opc_in;
         ovf_ff       <= ovf_in;
         flag_ff      <= flag_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
         out_last_ff  <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      rc_ff       <= rc_in;
      out_word_ff <= out_word_in;
   end

   `MWAS_ASSERT_ALWAYS(a_no_req_while_rsp, clock, reset, !(rsp_valid_ff && req_ready), "request taken while a response is pending")
   `MWAS_ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= CNT_W'(MAX_WORDS), "word count beyond MAX_WORDS")
   `MWAS_ASSERT_NEXT(a_last_starts_run, clock, reset, req_fire && req_ch.last_word, (state_ff == S_CLEAR) && (cnt_ff != '0), "last word did not start a computation")
   `MWAS_ASSERT_NEXT(a_run_ends_clean, clock, reset, rsp_fire && out_last_ff, (state_ff == S_COLLECT) && (cnt_ff == '0) && !ovf_ff, "state not cleared after the final response")

endmodule
